FILE: src/ssc_pkg.sv
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int CID_W   = 8;
  localparam int CONN_W  = 10;
  localparam int SEQ_W   = 32;
  localparam int CLIENTS = 1 << CID_W;

  localparam logic [SEQ_W-1:0] SEQ_START = SEQ_W'(1);

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_WRONG_CONN   = 2'd1,
    ST_SEQ_MISMATCH = 2'd2,
    ST_UNBOUND      = 2'd3
  } status_t;

  typedef enum logic {
    CMD_REQUEST  = 1'b0,
    CMD_RESPONSE = 1'b1
  } cmd_t;

  // One session entry as kept in the table
  typedef struct packed {
    logic [CONN_W-1:0] owner;
    logic [SEQ_W-1:0]  exp_seq;
    logic [SEQ_W-1:0]  rsp_seq;
  } row_t;

  typedef struct packed {
    logic bound;
    row_t row;
  } lookup_t;

  typedef struct packed {
    logic             accepted;
    status_t          status;
    logic [SEQ_W-1:0] out_seq;
  } result_t;

endpackage

FILE: src/ssc_table.sv
`timescale 1ns / 1ps

module ssc_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [ssc_pkg::CID_W-1:0] rd_addr,
  output ssc_pkg::lookup_t          rd_data,
  input  logic                      wr_en,
  input  logic [ssc_pkg::CID_W-1:0] wr_addr,
  input  ssc_pkg::row_t             wr_row
);
  import ssc_pkg::*;

  row_t               mem [CLIENTS];
  logic [CLIENTS-1:0] bound;
  row_t               rd_row;
  logic               rd_bound;

  // Bound bits double as valid bits for the rest of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      bound <= '0;
    end else if (wr_en) begin
      bound[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row   <= mem[rd_addr];
      rd_bound <= bound[rd_addr];
    end
  end

  // An unbound entry reads with both counters at their start value
  always_comb begin
    rd_data.bound       = rd_bound;
    rd_data.row.owner   = rd_row.owner;
    rd_data.row.exp_seq = rd_bound ? rd_row.exp_seq : SEQ_START;
    rd_data.row.rsp_seq = rd_bound ? rd_row.rsp_seq : SEQ_START;
  end

endmodule

FILE: src/ssc_check.sv
`timescale 1ns / 1ps

module ssc_check (
  input  logic                       cmd,
  input  logic [ssc_pkg::CONN_W-1:0] connection_id,
  input  logic [ssc_pkg::SEQ_W-1:0]  seq_num,
  input  ssc_pkg::lookup_t           entry,
  output ssc_pkg::result_t           result,
  output logic                       wr_en,
  output ssc_pkg::row_t              wr_row
);
  import ssc_pkg::*;

  logic [CONN_W-1:0] owner;

  // First request binds the client to its own connection
  assign owner = entry.bound ? entry.row.owner : connection_id;

  always_comb begin
    result.accepted = 1'b0;
    result.status   = ST_OK;
    result.out_seq  = '0;
    wr_row          = entry.row;
    wr_row.owner    = owner;
    wr_en           = 1'b0;
    if (cmd == CMD_RESPONSE) begin
      if (!entry.bound) begin
        result.status = ST_UNBOUND;
      end else begin
        result.accepted = 1'b1;
        result.out_seq  = entry.row.rsp_seq;
        wr_row.rsp_seq  = entry.row.rsp_seq + SEQ_START;
        wr_en           = 1'b1;
      end
    end else begin
      // Write back always: keeps a fresh binding even on a rejected request
      wr_en = 1'b1;
      if (owner != connection_id) begin
        result.status = ST_WRONG_CONN;
      end else if (entry.row.exp_seq != seq_num) begin
        result.status = ST_SEQ_MISMATCH;
      end else begin
        result.accepted = 1'b1;
        wr_row.exp_seq  = seq_num + SEQ_START;
      end
    end
  end

endmodule

FILE: src/session_sequence_checker.sv
`timescale 1ns / 1ps

// Per-client session checker. Each transfer is a request (cmd 0), checked
// against the client's bound connection and expected sequence number, or a
// response (cmd 1), stamped with the client's next outgoing sequence number.
// Session entries for 256 clients sit in a single-port-read, single-port-write
// table whose read data is registered. An item is handled by reading its
// client's entry, then deciding and writing the entry back; a new item is
// taken only once the write-back is done, and the decide step waits while the
// result register is held by out_ready. Reset clears every binding at once;
// there is no clearing pass.
module session_sequence_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic [ssc_pkg::CID_W-1:0]  client_id,
  input  logic [ssc_pkg::CONN_W-1:0] connection_id,
  input  logic [ssc_pkg::SEQ_W-1:0]  seq_num,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       accepted,
  output logic [1:0]                 status,
  output logic [ssc_pkg::SEQ_W-1:0]  out_seq
);
  import ssc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

  state_t            state, state_next;
  logic              cmd_q;
  logic [CID_W-1:0]  cid_q;
  logic [CONN_W-1:0] conn_q;
  logic [SEQ_W-1:0]  seq_q;
  logic              take_in;
  logic              out_free;
  logic              finish;
  lookup_t           entry;
  result_t           result;
  logic              chk_wr_en;
  row_t              wr_row;

  assign in_ready = (state == S_IDLE);
  assign take_in  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == S_LOOK) && out_free;

  ssc_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (take_in),
    .rd_addr (client_id),
    .rd_data (entry),
    .wr_en   (finish && chk_wr_en),
    .wr_addr (cid_q),
    .wr_row  (wr_row)
  );

  ssc_check u_check (
    .cmd           (cmd_q),
    .connection_id (conn_q),
    .seq_num       (seq_q),
    .entry         (entry),
    .result        (result),
    .wr_en         (chk_wr_en),
    .wr_row        (wr_row)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (take_in) state_next = S_LOOK;
      S_LOOK:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the item for the decide cycle
  always_ff @(posedge clk) begin
    if (take_in) begin
      cmd_q  <= cmd;
      cid_q  <= client_id;
      conn_q <= connection_id;
      seq_q  <= seq_num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      accepted <= result.accepted;
      status   <= result.status;
      out_seq  <= result.out_seq;
    end
  end

endmodule

FILE: verif/session_result_checker.sv
`timescale 1ns / 1ps

module session_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  ssc_pkg::cmd_t              cmd,
  input  logic [ssc_pkg::CID_W-1:0]  client_id,
  input  logic [ssc_pkg::CONN_W-1:0] connection_id,
  input  logic [ssc_pkg::SEQ_W-1:0]  seq_num,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       accepted,
  input  logic [1:0]                 status,
  input  logic [ssc_pkg::SEQ_W-1:0]  out_seq,
  output int                         fail_count,
  output int                         pending
);
  import ssc_pkg::*;

  logic             bound_tab   [CLIENTS];
  logic [CONN_W-1:0] owner_tab  [CLIENTS];
  logic [SEQ_W-1:0] req_seq_tab [CLIENTS];
  logic [SEQ_W-1:0] rsp_seq_tab [CLIENTS];

  result_t verdict_q [$];
  int      miss_count = 0;

  // Apply one transfer to the session table and return the verdict it earns.
  function automatic result_t judge_transfer(cmd_t c, logic [CID_W-1:0] id,
                                             logic [CONN_W-1:0] conn,
                                             logic [SEQ_W-1:0] seq);
    result_t r;
    r.accepted = 1'b0;
    r.status   = ST_UNBOUND;
    r.out_seq  = '0;
    if (c == CMD_RESPONSE) begin
      if (bound_tab[id]) begin
        r.accepted      = 1'b1;
        r.status        = ST_OK;
        r.out_seq       = rsp_seq_tab[id];
        rsp_seq_tab[id] = rsp_seq_tab[id] + 1'b1;
      end
      return r;
    end
    // first request binds, even if its sequence number turns out wrong
    if (!bound_tab[id]) begin
      bound_tab[id] = 1'b1;
      owner_tab[id] = conn;
    end
    if (owner_tab[id] != conn) begin
      r.status = ST_WRONG_CONN;
    end else if (req_seq_tab[id] != seq) begin
      r.status = ST_SEQ_MISMATCH;
    end else begin
      r.accepted      = 1'b1;
      r.status        = ST_OK;
      req_seq_tab[id] = seq + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int k = 0; k < CLIENTS; k++) begin
        bound_tab[k]   = 1'b0;
        owner_tab[k]   = '0;
        req_seq_tab[k] = SEQ_START;
        rsp_seq_tab[k] = SEQ_START;
      end
      verdict_q.delete();
    end else begin
      // check the outgoing transfer before queuing a new one from this edge
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("[%0t] unexpected result: accepted %0b status %0d out_seq %h",
                     $time, accepted, status, out_seq);
        end else begin
          want = verdict_q.pop_front();
          if (accepted !== want.accepted || status !== want.status ||
              out_seq !== want.out_seq) begin
            miss_count++;
            if (miss_count <= 10)
              $display("[%0t] mismatch: expected %0b/%0d/%h got %0b/%0d/%h",
                       $time, want.accepted, want.status, want.out_seq,
                       accepted, status, out_seq);
          end
        end
      end
      if (in_valid && in_ready)
        verdict_q.push_back(judge_transfer(cmd, client_id, connection_id, seq_num));
    end
    fail_count <= miss_count;
    pending    <= verdict_q.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import ssc_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int QUIET_TAIL   = 300;
  localparam int HOT          = 12;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 400000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  cmd_t              cmd = CMD_REQUEST;
  logic [CID_W-1:0]  client_id = '0;
  logic [CONN_W-1:0] connection_id = '0;
  logic [SEQ_W-1:0]  seq_num = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              accepted;
  logic [1:0]        status;
  logic [SEQ_W-1:0]  out_seq;

  int mismatches;
  int pending_results;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic long_hold = 1'b0;

  // sender-side view of each session, used only to build well-formed requests
  logic             gen_bound [CLIENTS];
  logic [CONN_W-1:0] gen_owner [CLIENTS];
  logic [SEQ_W-1:0] gen_next  [CLIENTS];

  session_sequence_checker u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .client_id     (client_id),
    .connection_id (connection_id),
    .seq_num       (seq_num),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .status        (status),
    .out_seq       (out_seq)
  );

  session_result_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .client_id     (client_id),
    .connection_id (connection_id),
    .seq_num       (seq_num),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .status        (status),
    .out_seq       (out_seq),
    .fail_count    (mismatches),
    .pending       (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void track_session(cmd_t c, logic [CID_W-1:0] id,
                                        logic [CONN_W-1:0] conn, logic [SEQ_W-1:0] seq);
    if (c != CMD_REQUEST) return;
    if (!gen_bound[id]) begin
      gen_bound[id] = 1'b1;
      gen_owner[id] = conn;
    end
    if (gen_owner[id] == conn && gen_next[id] == seq) gen_next[id] = seq + 1'b1;
  endfunction

  task automatic offer(cmd_t c, logic [CID_W-1:0] id, logic [CONN_W-1:0] conn,
                       logic [SEQ_W-1:0] seq);
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    client_id     <= id;
    connection_id <= conn;
    seq_num       <= seq;
    do @(posedge clk); while (!in_ready);
    track_session(c, id, conn, seq);
  endtask

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    int n;
    wait (!rst);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        n = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("session_sequence_checker regression: fail");
    $finish;
  end

  initial begin
    logic [CID_W-1:0]  hot_ids [HOT];
    logic [CID_W-1:0]  id;
    logic [CONN_W-1:0] conn;
    logic [SEQ_W-1:0]  seq;
    cmd_t              c;
    int                roll;

    for (int k = 0; k < CLIENTS; k++) begin
      gen_bound[k] = 1'b0;
      gen_owner[k] = '0;
      gen_next[k]  = SEQ_START;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unbound responses, binding, each reject, stamping, back to back
    offer(CMD_RESPONSE, 8'd0,   10'd0,    32'hFFFF_FFFF);
    offer(CMD_RESPONSE, 8'd255, 10'd1023, 32'h0);
    offer(CMD_REQUEST,  8'd0,   10'd0,    32'd1);
    offer(CMD_REQUEST,  8'd0,   10'd0,    32'd1);
    offer(CMD_REQUEST,  8'd0,   10'd1023, 32'd2);
    offer(CMD_REQUEST,  8'd0,   10'd0,    32'd2);
    offer(CMD_RESPONSE, 8'd0,   10'd1023, 32'hFFFF_FFFF);
    offer(CMD_RESPONSE, 8'd0,   10'd0,    32'h0);
    offer(CMD_REQUEST,  8'd255, 10'd1023, 32'hFFFF_FFFF);
    offer(CMD_REQUEST,  8'd255, 10'd0,    32'd1);
    offer(CMD_REQUEST,  8'd255, 10'd1023, 32'd1);
    offer(CMD_RESPONSE, 8'd255, 10'd0,    32'd0);
    offer(CMD_REQUEST,  8'd128, 10'd512,  32'd0);
    offer(CMD_REQUEST,  8'd128, 10'd512,  32'd1);
    offer(CMD_RESPONSE, 8'd1,   10'd512,  32'd1);
    offer(CMD_REQUEST,  8'd0,   10'd0,    32'd3);
    offer(CMD_REQUEST,  8'd0,   10'd0,    32'd4);
    offer(CMD_RESPONSE, 8'd0,   10'd0,    32'd0);
    offer(CMD_REQUEST,  8'd0,   10'd0,    32'd5);
    offer(CMD_REQUEST,  8'd0,   10'd0,    32'd5);
    offer(CMD_RESPONSE, 8'd0,   10'd0,    32'd0);
    offer(CMD_RESPONSE, 8'd0,   10'd0,    32'd0);
    offer(CMD_REQUEST,  8'd0,   10'd1,    32'd6);

    for (int k = 0; k < HOT; k++) hot_ids[k] = CID_W'($urandom);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) begin
        hot_ids[$urandom_range(0, HOT - 1)] = CID_W'($urandom);
        if (i >= RANDOM_ITEMS - QUIET_TAIL) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end else begin
          tx_idle_pct = 20 * $urandom_range(0, 3);
          rx_idle_pct = 20 * $urandom_range(0, 3);
        end
      end
      if (i == 600) long_hold = 1'b1;

      id   = hot_ids[$urandom_range(0, HOT - 1)];
      conn = gen_bound[id] ? gen_owner[id] : CONN_W'($urandom);
      seq  = gen_next[id];
      c    = CMD_REQUEST;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // well-formed request, leave as built
      end else if (roll < 80) begin
        c    = CMD_RESPONSE;
        conn = CONN_W'($urandom);
        seq  = $urandom;
      end else if (roll < 88) begin
        seq = $urandom_range(0, 1) ? seq + 1'b1 : SEQ_W'($urandom);
      end else if (roll < 93) begin
        conn = conn ^ CONN_W'($urandom_range(1, 1023));
      end else begin
        c    = cmd_t'($urandom_range(0, 1));
        id   = CID_W'($urandom);
        conn = CONN_W'($urandom);
        seq  = $urandom;
      end
      offer(c, id, conn, seq);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("session_sequence_checker regression: pass");
    end else begin
      $display("session_sequence_checker regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ssc_pkg.sv
src/ssc_table.sv
src/ssc_check.sv
src/session_sequence_checker.sv
verif/session_result_checker.sv
verif/tb.sv
